### sv/sfpr_pkg.sv
// Shared types and constants for the SysEx firmware page receiver.
package sfpr_pkg;

    localparam int HDR_LEN = 6;

    localparam logic [7:0] HDR_BYTES [HDR_LEN] = '{8'hF0, 8'h00, 8'h21, 8'h02, 8'h00, 8'h04};

    localparam logic [7:0] BYTE_SOX      = 8'hF0;
    localparam logic [7:0] BYTE_EOX      = 8'hF7;
    localparam logic [7:0] BYTE_STATUS   = 8'h80;
    localparam logic [6:0] CMD_RESET     = 7'h7F;
    localparam logic [6:0] CMD_PAGE      = 7'h7E;
    localparam logic [6:0] CMD_SUB_ZERO  = 7'h00;
    localparam logic [3:0] NIBBLE_MASK   = 4'hF;

    typedef enum logic [2:0] {
        EV_HDR_OK    = 3'd0,
        EV_HDR_BAD   = 3'd1,
        EV_PAGE_WORD = 3'd2,
        EV_RESET_REQ = 3'd3,
        EV_FRAME_ERR = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        PS_HDR  = 2'd0,
        PS_CMD  = 2'd1,
        PS_DATA = 2'd2
    } parse_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_LO,
        ST_RD_HI,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic         byte_valid;
        logic         is_rt;
        logic         is_data;
        logic         is_eox;
        logic [HDR_LEN-1:0] hdr_hit;
        logic         cmd_reset;
        logic         cmd_page;
        logic         buf_full;
        logic         buf_room;
        logic         sum_ok;
        logic         out_free;
        logic         emit_last;
    } dp_status_t;

    typedef struct packed {
        logic         take_byte;
        logic         store_cmd;
        logic         cmd_sel;
        logic         clear_page;
        logic         hold_high;
        logic         write_byte;
        logic         out_load;
        event_t       out_event;
        logic         emit_start;
        logic         rd_lo;
        logic         rd_hi;
        logic         emit_word;
    } dp_cmd_t;

endpackage

### sv/sfpr_datapath.sv
// Datapath: byte register, command bytes, page buffer memory, checksum and output register.
module sfpr_datapath
    import sfpr_pkg::*;
#(
    parameter int PAGE_BYTES = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic [7:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  dp_cmd_t     cmd,
    output dp_status_t  status
);

    localparam int BUF_DEPTH = PAGE_BYTES + 1;
    localparam int AW = $clog2(BUF_DEPTH);
    localparam int IW = $clog2(BUF_DEPTH + 1);

    logic [7:0]    byte_reg;
    logic [6:0]    cmd0_reg;
    logic [6:0]    cmd1_reg;
    logic [3:0]    high_nib_reg;
    logic [IW-1:0] idx_reg;
    logic [7:0]    sum_reg;
    logic [7:0]    chk_reg;
    logic [15:0]   page_addr_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [7:0]    rd_data_reg;
    logic [7:0]    lo_byte_reg;
    logic [7:0]    mem [BUF_DEPTH];

    logic          out_valid_reg;
    event_t        out_event_reg;
    logic [15:0]   out_addr_reg;
    logic [15:0]   out_word_reg;
    logic          out_last_reg;

    logic [7:0]    full_byte;
    logic [AW-1:0] rd_addr;
    logic [AW:0]   rd_idx_plus2;

    assign full_byte    = {high_nib_reg, byte_reg[3:0] & NIBBLE_MASK};
    assign rd_addr      = cmd.rd_hi ? rd_idx_reg + AW'(1) : rd_idx_reg;
    assign rd_idx_plus2 = {1'b0, rd_idx_reg} + (AW + 1)'(2);

    always_comb
    begin
        status.byte_valid = s_axis_tvalid;
        status.is_rt      = (byte_reg > BYTE_SOX) && (byte_reg != BYTE_EOX);
        status.is_data    = byte_reg < BYTE_STATUS;
        status.is_eox     = byte_reg == BYTE_EOX;
        for (int k = 0; k < HDR_LEN; k++)
        begin
            status.hdr_hit[k] = byte_reg == HDR_BYTES[k];
        end
        status.cmd_reset  = (cmd0_reg == CMD_RESET) && (cmd1_reg == CMD_SUB_ZERO);
        status.cmd_page   = (cmd0_reg == CMD_PAGE) && (cmd1_reg == CMD_SUB_ZERO);
        status.buf_full   = idx_reg == IW'(BUF_DEPTH);
        status.buf_room   = idx_reg < IW'(BUF_DEPTH);
        status.sum_ok     = chk_reg == sum_reg;
        status.out_free   = !out_valid_reg || m_axis_tready;
        status.emit_last  = rd_idx_plus2 >= (AW + 1)'(PAGE_BYTES);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && s_axis_tvalid)
        begin
            byte_reg <= s_axis_tdata;
        end
        if (cmd.store_cmd)
        begin
            if (cmd.cmd_sel)
            begin
                cmd1_reg <= byte_reg[6:0];
            end
            else
            begin
                cmd0_reg <= byte_reg[6:0];
            end
        end
        if (cmd.hold_high)
        begin
            high_nib_reg <= byte_reg[3:0];
        end
        if (cmd.write_byte && (idx_reg == IW'(PAGE_BYTES)))
        begin
            chk_reg <= full_byte;
        end
        if (cmd.rd_hi)
        begin
            lo_byte_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_byte)
        begin
            mem[idx_reg[AW-1:0]] <= full_byte;
        end
        if (cmd.rd_lo || cmd.rd_hi)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            page_addr_reg <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            if (cmd.clear_page)
            begin
                idx_reg <= '0;
                sum_reg <= '0;
            end
            else if (cmd.write_byte)
            begin
                idx_reg <= idx_reg + IW'(1);
                if (idx_reg < IW'(PAGE_BYTES))
                begin
                    sum_reg <= sum_reg + full_byte;
                end
            end
            if (cmd.emit_start)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.emit_word)
            begin
                rd_idx_reg <= rd_idx_plus2[AW-1:0];
                if (status.emit_last)
                begin
                    page_addr_reg <= page_addr_reg + 16'(PAGE_BYTES);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load || cmd.emit_word)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_word)
        begin
            out_event_reg <= EV_PAGE_WORD;
            out_addr_reg  <= page_addr_reg + 16'(rd_idx_reg);
            out_word_reg  <= {rd_data_reg, lo_byte_reg};
            out_last_reg  <= status.emit_last;
        end
        else if (cmd.out_load)
        begin
            out_event_reg <= cmd.out_event;
            out_addr_reg  <= '0;
            out_word_reg  <= '0;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_word_reg, out_addr_reg, out_event_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

### sv/sfpr_ctrl.sv
// Controller: frame parser state and the sequencer for page readout.
module sfpr_ctrl
    import sfpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    parse_t      parse_reg, parse_next;
    logic [2:0]  hp_reg, hp_next;
    logic        cc_reg, cc_next;
    logic        nib_reg, nib_next;
    logic        seen_reg, seen_next;
    logic        done_reg, done_next;
    logic        hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            parse_reg <= PS_HDR;
            hp_reg    <= '0;
            cc_reg    <= 1'b0;
            nib_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            parse_reg <= parse_next;
            hp_reg    <= hp_next;
            cc_reg    <= cc_next;
            nib_reg   <= nib_next;
            seen_reg  <= seen_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < HDR_LEN; k++)
        begin
            hit = hit | ((hp_reg == 3'(k)) && status.hdr_hit[k]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        parse_next = parse_reg;
        hp_next    = hp_reg;
        cc_next    = cc_reg;
        nib_next   = nib_reg;
        seen_next  = seen_reg;
        done_next  = done_reg;
        cmd        = '0;
        cmd.cmd_sel   = cc_reg;
        cmd.out_event = EV_HDR_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take_byte = 1'b1;
                if (status.byte_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                    if (!done_reg && !status.is_rt)
                    begin
                        unique case (parse_reg)
                            PS_CMD:
                            begin
                                if (status.is_data)
                                begin
                                    cmd.store_cmd = 1'b1;
                                    if (cc_reg)
                                    begin
                                        cc_next        = 1'b0;
                                        cmd.clear_page = 1'b1;
                                        nib_next       = 1'b0;
                                        seen_next      = 1'b0;
                                        parse_next     = PS_DATA;
                                    end
                                    else
                                    begin
                                        cc_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    parse_next = PS_HDR;
                                    hp_next    = '0;
                                    cc_next    = 1'b0;
                                end
                            end
                            PS_DATA:
                            begin
                                if (status.is_data)
                                begin
                                    seen_next = 1'b1;
                                    if (status.buf_room)
                                    begin
                                        if (nib_reg)
                                        begin
                                            cmd.write_byte = 1'b1;
                                            nib_next       = 1'b0;
                                        end
                                        else
                                        begin
                                            cmd.hold_high = 1'b1;
                                            nib_next      = 1'b1;
                                        end
                                    end
                                end
                                else if (status.is_eox)
                                begin
                                    if (status.cmd_reset && !seen_reg)
                                    begin
                                        cmd.out_load  = 1'b1;
                                        cmd.out_event = EV_RESET_REQ;
                                        done_next     = 1'b1;
                                    end
                                    else if (status.buf_full && status.cmd_page && status.sum_ok)
                                    begin
                                        cmd.emit_start = 1'b1;
                                        state_next     = ST_RD_LO;
                                    end
                                    else
                                    begin
                                        cmd.out_load  = 1'b1;
                                        cmd.out_event = EV_FRAME_ERR;
                                    end
                                    parse_next = PS_HDR;
                                    hp_next    = '0;
                                    nib_next   = 1'b0;
                                    seen_next  = 1'b0;
                                end
                            end
                            default:
                            begin
                                cmd.out_load = 1'b1;
                                if (hit)
                                begin
                                    cmd.out_event = EV_HDR_OK;
                                    if (hp_reg == 3'(HDR_LEN - 1))
                                    begin
                                        hp_next    = '0;
                                        cc_next    = 1'b0;
                                        parse_next = PS_CMD;
                                    end
                                    else
                                    begin
                                        hp_next = hp_reg + 3'd1;
                                    end
                                end
                                else
                                begin
                                    cmd.out_event = EV_HDR_BAD;
                                    hp_next       = '0;
                                    parse_next    = PS_HDR;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_RD_LO:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                cmd.rd_hi  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_word = 1'b1;
                    state_next    = status.emit_last ? ST_IDLE : ST_RD_LO;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/sysex_firmware_page_receiver.sv
// Top level of the SysEx firmware page receiver: controller joined to datapath.
// Each received byte is accepted in the idle state and then decoded in the decode state.
// A single-result byte is loaded into the output register at decode and shows its transfer in the cycle after.
// A good page is read from the buffer memory over one read port: each word passes the read-low,
// read-high and emit states in turn, and the emit state waits on any output back-pressure.
// Reset clears all control state asynchronously; the page buffer is not cleared.
module sysex_firmware_page_receiver
    import sfpr_pkg::*;
#(
    parameter int PAGE_BYTES = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // event_res, flash_address, data_word, zero fill
    output logic        m_axis_tlast
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sfpr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    sfpr_datapath #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .status        (status)
    );

    assign s_axis_tready = cmd.take_byte;

endmodule
